FILE: rtl/core/ffea_pkg.sv
// ffea_pkg: shared constants, types and codes for the first-fit extent allocator
// no dependencies; used by ffea_cell, ffea_ctrl and first_fit_extent_allocator_unit

package ffea_pkg;

  // unit size must be a power of two (rounding is done with a mask)
  localparam int unsigned UNIT_BYTES  = 16;
  localparam int unsigned MAX_EXTENTS = 64;
  localparam int unsigned ADDR_BITS   = 32;

  // cell index and extent count widths
  localparam int unsigned IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);

  typedef logic [ADDR_BITS-1:0] addr_t;

  localparam addr_t UNIT_MASK = addr_t'(UNIT_BYTES - 1);
  localparam addr_t HDR_BYTES = addr_t'(UNIT_BYTES);
  localparam addr_t RND_BYTES = addr_t'(2 * UNIT_BYTES - 1);
  localparam addr_t NEED_LIM  = addr_t'({ADDR_BITS{1'b1}}) - RND_BYTES;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_FREE   = 2'd2,
    OP_SHRINK = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_FIT = 2'd1,
    ST_FULL   = 2'd2,
    ST_MOVE   = 2'd3
  } status_e;

  typedef struct packed {
    addr_t start;
    addr_t length;
  } extent_t;

  // controller to chain: shift strobe and entry entering the tail cell
  typedef struct packed {
    logic    shift;
    extent_t emit;
  } chain_ctl_t;

  // chain to controller: the two cells at the head
  typedef struct packed {
    extent_t e0;
    extent_t e1;
  } head_t;

endpackage

FILE: rtl/core/ffea_cell.sv
// ffea_cell: one extent slot of the shift chain
// depends on ffea_pkg

module ffea_cell (
  input  logic              clk_i,
  input  logic              shift_i,
  input  ffea_pkg::extent_t d_i,
  output ffea_pkg::extent_t q_o
);

  ffea_pkg::extent_t ext_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      ext_q <= d_i;
    end
  end

  assign q_o = ext_q;

endmodule

FILE: rtl/core/ffea_ctrl.sv
// ffea_ctrl: sequencer at the head of the extent chain (scan, decide, rewrite)
// depends on ffea_pkg

module ffea_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           operation_i,
  input  logic [31:0]          address_i,
  input  logic [31:0]          request_bytes_i,
  input  logic [31:0]          block_bytes_i,
  output logic                 result_valid_o,
  output logic [1:0]           status_o,
  output logic [31:0]          payload_address_o,
  output logic [31:0]          granted_bytes_o,
  input  ffea_pkg::head_t      head_i,
  output ffea_pkg::chain_ctl_t chain_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PREP = 6'b000010,
    S_SCAN = 6'b000100,
    S_EVAL = 6'b001000,
    S_EDIT = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  typedef enum logic [1:0] {
    M_NORM  = 2'd0,
    M_SKIP  = 2'd1,
    M_DELAY = 2'd2
  } mode_e;

  localparam logic [ffea_pkg::IW-1:0] LAST_IDX = ffea_pkg::IW'(ffea_pkg::MAX_EXTENTS - 1);
  localparam logic [ffea_pkg::CW-1:0] MAX_CNT  = ffea_pkg::CW'(ffea_pkg::MAX_EXTENTS);

  // control state
  state_e                  state_q, state_d;
  mode_e                   mode_q, mode_d;
  logic [ffea_pkg::CW-1:0] count_q, count_d;
  logic [ffea_pkg::IW-1:0] j_q, j_d;
  logic                    alloc_q, alloc_d;
  logic                    found_q, found_d;
  logic                    mod_en_q, mod_en_d, del_en_q, del_en_d, ins_en_q, ins_en_d;

  // payload
  ffea_pkg::op_e           op_q, op_d;
  ffea_pkg::addr_t         addr_q, addr_d, req_q, req_d, blk_q, blk_d;
  ffea_pkg::addr_t         ps_q, ps_d, pl_q, pl_d, pe_q, pe_d, need_q, need_d;
  ffea_pkg::status_e       st_q, st_d;
  ffea_pkg::addr_t         pay_q, pay_d, gr_q, gr_d, gr_ok_q, gr_ok_d, gr_full_q, gr_full_d;
  ffea_pkg::extent_t       prev_q, prev_d, lo_q, lo_d, up_q, up_d;
  logic                    lo_ok_q, lo_ok_d, up_ok_q, up_ok_d;
  logic [ffea_pkg::CW-1:0] p_q, p_d;
  logic [ffea_pkg::IW-1:0] mod_idx_q, mod_idx_d, del_idx_q, del_idx_d, ins_idx_q, ins_idx_d;
  ffea_pkg::extent_t       mod_val_q, mod_val_d, ins_val_q, ins_val_d, hold_q, hold_d;

  ffea_pkg::extent_t       in0, in1;
  ffea_pkg::addr_t         prev_end, blk_r, bs, need, len_r;
  logic                    need_ok, j_in, hit, lower, upper;
  ffea_pkg::extent_t       lo_sel;
  logic [ffea_pkg::CW-1:0] p_eff;

  assign in0      = head_i.e0;
  assign in1      = head_i.e1;
  assign prev_end = prev_q.start + prev_q.length;
  assign j_in     = (ffea_pkg::CW'(j_q) < count_q);

  always_comb begin
    state_d = state_q;  mode_d = mode_q;  count_d = count_q;  j_d = j_q;
    alloc_d = alloc_q;  found_d = found_q;
    mod_en_d = mod_en_q;  del_en_d = del_en_q;  ins_en_d = ins_en_q;
    op_d = op_q;  addr_d = addr_q;  req_d = req_q;  blk_d = blk_q;
    ps_d = ps_q;  pl_d = pl_q;  pe_d = pe_q;  need_d = need_q;
    st_d = st_q;  pay_d = pay_q;  gr_d = gr_q;  gr_ok_d = gr_ok_q;  gr_full_d = gr_full_q;
    prev_d = prev_q;  lo_d = lo_q;  up_d = up_q;  lo_ok_d = lo_ok_q;  up_ok_d = up_ok_q;
    p_d = p_q;  mod_idx_d = mod_idx_q;  del_idx_d = del_idx_q;  ins_idx_d = ins_idx_q;
    mod_val_d = mod_val_q;  ins_val_d = ins_val_q;  hold_d = hold_q;
    chain_o.shift = 1'b0;
    chain_o.emit  = in0;

    blk_r   = blk_q & ~ffea_pkg::UNIT_MASK;
    bs      = addr_q - ffea_pkg::HDR_BYTES;
    need_ok = (req_q <= ffea_pkg::NEED_LIM);
    need    = (req_q + ffea_pkg::RND_BYTES) & ~ffea_pkg::UNIT_MASK;
    len_r   = req_q & ~ffea_pkg::UNIT_MASK;
    hit     = alloc_q ? (in0.length >= need_q) : (in0.start >= ps_q);
    lower   = found_q ? lo_ok_q : ((count_q != '0) && (prev_end == ps_q));
    lo_sel  = found_q ? lo_q : prev_q;
    upper   = found_q && up_ok_q;
    p_eff   = found_q ? p_q : count_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d    = ffea_pkg::op_e'(operation_i);
          addr_d  = ffea_pkg::ADDR_BITS'(address_i);
          req_d   = ffea_pkg::ADDR_BITS'(request_bytes_i);
          blk_d   = ffea_pkg::ADDR_BITS'(block_bytes_i);
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        st_d = ffea_pkg::ST_OK;  pay_d = '0;  gr_d = '0;
        gr_ok_d = '0;  gr_full_d = '0;
        need_d = need;  j_d = '0;  found_d = 1'b0;
        state_d = S_DONE;
        case (op_q)
          ffea_pkg::OP_ADD: begin
            if (len_r != '0) begin
              alloc_d = 1'b0;  ps_d = addr_q;  pl_d = len_r;  pe_d = addr_q + len_r;
              gr_ok_d = len_r;  state_d = S_SCAN;
            end
          end
          ffea_pkg::OP_ALLOC: begin
            if (!need_ok) begin
              st_d = ffea_pkg::ST_NO_FIT;
            end else begin
              alloc_d = 1'b1;  state_d = S_SCAN;
            end
          end
          ffea_pkg::OP_FREE: begin
            if (addr_q != '0 && blk_r != '0) begin
              alloc_d = 1'b0;  ps_d = bs;  pl_d = blk_r;  pe_d = bs + blk_r;
              state_d = S_SCAN;
            end
          end
          default: begin
            if (addr_q == '0) begin
              // null payload shrinks like an allocate
              if (!need_ok) begin
                st_d = ffea_pkg::ST_NO_FIT;
              end else begin
                alloc_d = 1'b1;  state_d = S_SCAN;
              end
            end else if (!need_ok) begin
              st_d = ffea_pkg::ST_NO_FIT;
            end else if (need > blk_r) begin
              st_d = ffea_pkg::ST_MOVE;
            end else if (need == blk_r) begin
              pay_d = addr_q;  gr_d = blk_r;
            end else begin
              alloc_d = 1'b0;  ps_d = bs + need;  pl_d = blk_r - need;  pe_d = bs + blk_r;
              pay_d = addr_q;  gr_ok_d = need;  gr_full_d = blk_r;
              state_d = S_SCAN;
            end
          end
        endcase
      end
      S_SCAN: begin
        chain_o.shift = 1'b1;
        if (!found_q && j_in && hit) begin
          found_d = 1'b1;
          p_d     = ffea_pkg::CW'(j_q);
          up_d    = in0;
          up_ok_d = (in0.start == pe_q);
          lo_ok_d = (j_q != '0) && (prev_end == ps_q);
          lo_d    = prev_q;
        end
        if (j_in) begin
          prev_d = in0;
        end
        if (j_q == LAST_IDX) begin
          j_d = '0;  state_d = S_EVAL;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_EVAL: begin
        mod_en_d = 1'b0;  del_en_d = 1'b0;  ins_en_d = 1'b0;  mode_d = M_NORM;
        state_d = S_EDIT;
        if (alloc_q) begin
          if (!found_q) begin
            st_d = ffea_pkg::ST_NO_FIT;  state_d = S_DONE;
          end else begin
            pay_d = up_q.start + ffea_pkg::HDR_BYTES;
            gr_d  = need_q;
            if (up_q.length > need_q) begin
              mod_en_d = 1'b1;  mod_idx_d = ffea_pkg::IW'(p_q);
              mod_val_d.start  = up_q.start + need_q;
              mod_val_d.length = up_q.length - need_q;
            end else begin
              del_en_d = 1'b1;  del_idx_d = ffea_pkg::IW'(p_q);  count_d = count_q - 1'b1;
            end
          end
        end else begin
          gr_d = gr_ok_q;
          if (lower) begin
            mod_en_d = 1'b1;  mod_idx_d = ffea_pkg::IW'(p_eff - 1'b1);
            mod_val_d.start = lo_sel.start;
            if (upper) begin
              mod_val_d.length = lo_sel.length + pl_q + up_q.length;
              del_en_d = 1'b1;  del_idx_d = ffea_pkg::IW'(p_q);  count_d = count_q - 1'b1;
            end else begin
              mod_val_d.length = lo_sel.length + pl_q;
            end
          end else if (upper) begin
            mod_en_d = 1'b1;  mod_idx_d = ffea_pkg::IW'(p_q);
            mod_val_d.start  = ps_q;
            mod_val_d.length = up_q.length + pl_q;
          end else if (count_q >= MAX_CNT) begin
            st_d = ffea_pkg::ST_FULL;  gr_d = gr_full_q;  state_d = S_DONE;
          end else begin
            ins_en_d = 1'b1;  ins_idx_d = ffea_pkg::IW'(p_eff);  count_d = count_q + 1'b1;
            ins_val_d.start  = ps_q;
            ins_val_d.length = pl_q;
          end
        end
      end
      S_EDIT: begin
        chain_o.shift = 1'b1;
        if (ins_en_q && j_q == ins_idx_q) begin
          chain_o.emit = ins_val_q;  mode_d = M_DELAY;  hold_d = in0;
        end else if (del_en_q && j_q == del_idx_q) begin
          chain_o.emit = in1;  mode_d = M_SKIP;
        end else if (mod_en_q && j_q == mod_idx_q) begin
          chain_o.emit = mod_val_q;
        end else begin
          case (mode_q)
            M_SKIP:  chain_o.emit = in1;
            M_DELAY: begin
              chain_o.emit = hold_q;  hold_d = in0;
            end
            default: chain_o.emit = in0;
          endcase
        end
        if (j_q == LAST_IDX) begin
          j_d = '0;  state_d = S_DONE;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mode_q   <= M_NORM;
      count_q  <= '0;
      j_q      <= '0;
      alloc_q  <= 1'b0;
      found_q  <= 1'b0;
      mod_en_q <= 1'b0;
      del_en_q <= 1'b0;
      ins_en_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      count_q  <= count_d;
      j_q      <= j_d;
      alloc_q  <= alloc_d;
      found_q  <= found_d;
      mod_en_q <= mod_en_d;
      del_en_q <= del_en_d;
      ins_en_q <= ins_en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;  addr_q <= addr_d;  req_q <= req_d;  blk_q <= blk_d;
    ps_q <= ps_d;  pl_q <= pl_d;  pe_q <= pe_d;  need_q <= need_d;
    st_q <= st_d;  pay_q <= pay_d;  gr_q <= gr_d;  gr_ok_q <= gr_ok_d;  gr_full_q <= gr_full_d;
    prev_q <= prev_d;  lo_q <= lo_d;  up_q <= up_d;  lo_ok_q <= lo_ok_d;  up_ok_q <= up_ok_d;
    p_q <= p_d;  mod_idx_q <= mod_idx_d;  del_idx_q <= del_idx_d;  ins_idx_q <= ins_idx_d;
    mod_val_q <= mod_val_d;  ins_val_q <= ins_val_d;  hold_q <= hold_d;
  end

  assign busy              = (state_q != S_IDLE);
  assign result_valid_o    = (state_q == S_DONE);
  assign status_o          = st_q;
  assign payload_address_o = 32'(pay_q);
  assign granted_bytes_o   = 32'(gr_q);

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted transaction did not raise busy");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_CNT) else $error("extent count above table size");

  a_count_stable_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |=> $stable(count_q)) else $error("count changed during scan");

  a_one_edit_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EDIT) |-> !(ins_en_q && del_en_q)) else $error("insert and delete together");

endmodule

FILE: rtl/core/first_fit_extent_allocator_unit.sv
// first_fit_extent_allocator_unit: top level, chain of extent cells plus head sequencer
// depends on ffea_pkg, ffea_cell, ffea_ctrl
//
// channel   direction  handshake                      payload
// command   in         start high, busy low           operation_i address_i
//                                                     request_bytes_i block_bytes_i
// result    out        result_valid_o, one cycle      status_o payload_address_o
//                                                     granted_bytes_o
//
// one transaction at a time; busy stays high from acceptance to the result strobe
// operations that never touch the table go through accept, decode and result
// table operations go through accept, decode, one full rotation of the cell chain
//   to search, one decision step, one more rotation to rewrite, and result;
//   a failed allocate or a full table skips the rewrite
// reset clears the extent count and sequencer state, not the cells; cell contents are unused until written
// the receiver cannot stall: the result is shown for exactly one cycle

module first_fit_extent_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [31:0] address_i,
  input  logic [31:0] request_bytes_i,
  input  logic [31:0] block_bytes_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [31:0] payload_address_o,
  output logic [31:0] granted_bytes_o
);

  // extent slots, entry k sits in cell k whenever the chain is at rest
  ffea_pkg::extent_t    cell_q [ffea_pkg::MAX_EXTENTS];
  ffea_pkg::chain_ctl_t chain;
  ffea_pkg::head_t      head;

  // head cells feed the sequencer; it needs a lookahead of one for deletes
  assign head.e0 = cell_q[0];
  assign head.e1 = cell_q[1];

  ffea_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .operation_i       (operation_i),
    .address_i         (address_i),
    .request_bytes_i   (request_bytes_i),
    .block_bytes_i     (block_bytes_i),
    .result_valid_o    (result_valid_o),
    .status_o          (status_o),
    .payload_address_o (payload_address_o),
    .granted_bytes_o   (granted_bytes_o),
    .head_i            (head),
    .chain_o           (chain)
  );

  // chain shifts toward the head; the sequencer refills the tail cell
  for (genvar i = 0; i < ffea_pkg::MAX_EXTENTS; i++) begin : g_cell
    ffea_pkg::extent_t cell_d;
    if (i == ffea_pkg::MAX_EXTENTS - 1) begin : g_tail
      assign cell_d = chain.emit;
    end else begin : g_body
      assign cell_d = cell_q[i+1];
    end
    ffea_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (chain.shift),
      .d_i     (cell_d),
      .q_o     (cell_q[i])
    );
  end

endmodule

FILE: tb/sv/first_fit_extent_allocator_unit_checker.sv
// checker for the first-fit extent allocator: watches command and result ports,
// predicts each result from its own free-extent table and compares; needs ffea_pkg

module first_fit_extent_allocator_unit_checker
  import ffea_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [31:0] address_i,
  input  logic [31:0] request_bytes_i,
  input  logic [31:0] block_bytes_i,
  input  logic        result_valid_o,
  input  logic [1:0]  status_o,
  input  logic [31:0] payload_address_o,
  input  logic [31:0] granted_bytes_o,
  output int          fail_count,
  output int          pending_count,
  output int          free_extents
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e st;
    addr_t   pay;
    addr_t   gr;
  } alloc_result_t;

  addr_t         ext_start[$];
  addr_t         ext_len[$];
  alloc_result_t expected_results[$];
  int            mismatches;

  assign fail_count    = mismatches;

  function automatic bit round_need(addr_t req, output addr_t need);
    if (req > NEED_LIM) return 0;
    need = (req + RND_BYTES) & ~UNIT_MASK;
    return 1;
  endfunction

  function automatic status_e free_piece(addr_t bs, addr_t bl);
    int p;
    p = 0;
    if (bl == 0) return ST_OK;
    while (p < ext_start.size() && ext_start[p] < bs) p++;
    if (p > 0 && addr_t'(ext_start[p-1] + ext_len[p-1]) == bs) begin
      ext_len[p-1] += bl;
      if (p < ext_start.size() && addr_t'(ext_start[p-1] + ext_len[p-1]) == ext_start[p]) begin
        ext_len[p-1] += ext_len[p];
        ext_start.delete(p);
        ext_len.delete(p);
      end
      return ST_OK;
    end
    if (p < ext_start.size() && addr_t'(bs + bl) == ext_start[p]) begin
      ext_start[p] = bs;
      ext_len[p] += bl;
      return ST_OK;
    end
    if (ext_start.size() >= MAX_EXTENTS) return ST_FULL;
    ext_start.insert(p, bs);
    ext_len.insert(p, bl);
    return ST_OK;
  endfunction

  function automatic alloc_result_t first_fit(addr_t req);
    alloc_result_t r;
    addr_t need, bs;
    r = '{ST_NO_FIT, '0, '0};
    if (!round_need(req, need)) return r;
    foreach (ext_len[i]) begin
      if (ext_len[i] >= need) begin
        bs = ext_start[i];
        if (ext_len[i] > need) begin
          ext_start[i] = bs + need;
          ext_len[i] -= need;
        end else begin
          ext_start.delete(i);
          ext_len.delete(i);
        end
        r = '{ST_OK, bs + HDR_BYTES, need};
        return r;
      end
    end
    return r;
  endfunction

  function automatic alloc_result_t predict_result(op_e op, addr_t addr, addr_t req, addr_t blk);
    alloc_result_t r;
    addr_t bs, need, len;
    r  = '{ST_OK, '0, '0};
    bs = addr - HDR_BYTES;
    blk &= ~UNIT_MASK;
    case (op)
      OP_ADD: begin
        len = req & ~UNIT_MASK;
        r.st = free_piece(addr, len);
        if (r.st == ST_OK) r.gr = len;
      end
      OP_ALLOC: r = first_fit(req);
      OP_FREE: if (addr != 0) r.st = free_piece(bs, blk);
      default: begin
        if (addr == 0) r = first_fit(req);
        else if (!round_need(req, need)) r.st = ST_NO_FIT;
        else if (need > blk) r.st = ST_MOVE;
        else if (need == blk) r = '{ST_OK, addr, blk};
        else begin
          r.st  = free_piece(bs + need, blk - need);
          r.pay = addr;
          r.gr  = (r.st == ST_OK) ? need : blk;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t e;
    if (!rst_ni) begin
      ext_start.delete();
      ext_len.delete();
      expected_results.delete();
      mismatches    <= 0;
      pending_count <= 0;
      free_extents  <= 0;
    end else begin
      if (result_valid_o) begin
        if (expected_results.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result status %0d", status_o);
        end else begin
          e = expected_results.pop_front();
          if (status_o !== e.st || payload_address_o !== e.pay || granted_bytes_o !== e.gr) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: exp st %0d pay %h gr %h, got st %0d pay %h gr %h",
                       e.st, e.pay, e.gr, status_o, payload_address_o, granted_bytes_o);
          end
        end
      end
      if (start && !busy)
        expected_results.push_back(predict_result(op_e'(operation_i), address_i,
                                                  request_bytes_i, block_bytes_i));
      pending_count <= expected_results.size();
      free_extents  <= ext_start.size();
    end
  end
endmodule

FILE: tb/sv/first_fit_extent_allocator_unit_test.sv
// top of the allocator testbench: clock, reset, command stimulus and verdict
// depends on ffea_pkg, first_fit_extent_allocator_unit and its checker module

module first_fit_extent_allocator_unit_test;
  import ffea_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_CYCLES = 2 * MAX_EXTENTS + 3;
  localparam int WATCHDOG_LIMIT = 20 * (TABLE_CYCLES + 20);

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  operation_i = '0;
  logic [31:0] address_i = '0;
  logic [31:0] request_bytes_i = '0;
  logic [31:0] block_bytes_i = '0;
  logic        result_valid_o;
  logic [1:0]  status_o;
  logic [31:0] payload_address_o;
  logic [31:0] granted_bytes_o;
  int          fail_count, pending_count, free_extents;
  int          idle_cycles;

  // live blocks handed out, so frees and shrinks mostly hit real blocks
  addr_t live_pay[$];
  addr_t live_size[$];

  always #4 clk_i = ~clk_i;

  first_fit_extent_allocator_unit DUT (.*);

  first_fit_extent_allocator_unit_checker checker_inst (.*);

  // watchdog: cycles with no accepted transaction on either side
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // drive one command and hold until accepted
  task automatic issue(op_e op, addr_t addr, addr_t req, addr_t blk);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    repeat (gap) @(posedge clk_i);
    start           <= 1'b1;
    operation_i     <= op;
    address_i       <= addr;
    request_bytes_i <= req;
    block_bytes_i   <= blk;
    do @(posedge clk_i); while (busy);
    start <= 1'b0;
    // wait for the result so live block bookkeeping follows it
    while (!result_valid_o) @(posedge clk_i);
    if (status_o == ST_OK && granted_bytes_o != 0 && (op == OP_ALLOC ||
        (op == OP_SHRINK && addr == 0))) begin
      live_pay.push_back(payload_address_o);
      live_size.push_back(granted_bytes_o);
    end
  endtask

  task automatic drain();
    while (pending_count != 0) @(posedge clk_i);
    repeat (TABLE_CYCLES + 5) @(posedge clk_i);
  endtask

  // pick a live block; free or shrink it and update the list
  task automatic touch_live(bit do_free);
    int k;
    addr_t p, s, r;
    k = $urandom_range(0, live_pay.size() - 1);
    p = live_pay[k];
    s = live_size[k];
    if (do_free || s <= 2 * UNIT_BYTES) begin
      issue(OP_FREE, p, $urandom, s | $urandom_range(0, 15));
      live_pay.delete(k);
      live_size.delete(k);
    end else begin
      r = $urandom_range(0, s);
      issue(OP_SHRINK, p, r, s);
      if (status_o == ST_OK) live_size[k] = granted_bytes_o;
    end
  endtask

  initial begin
    addr_t base;
    int    pick;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: edge values, every operation, each special case
    issue(OP_ALLOC, 32'd10, 32'd16, 32'd0);             // empty table, no fit
    issue(OP_ADD, 32'h1000, 32'd15, 32'd0);             // empty region after rounding
    issue(OP_ADD, 32'h1000, 32'h1007, 32'd0);           // region, length rounded down
    issue(OP_ADD, 32'h3000, 32'h1000, 32'd0);           // region not adjacent, stays separate
    issue(OP_ADD, 32'h0800, 32'h0800, 32'd0);           // merges with higher extent
    issue(OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // rounding overflow
    issue(OP_ALLOC, 32'd0, 32'hFFFF_FFE0, 32'd0);       // largest roundable, no fit
    issue(OP_ALLOC, 32'd0, 32'd0, 32'd0);               // smallest block
    issue(OP_ALLOC, 32'd0, 32'd100, 32'd0);
    issue(OP_FREE, 32'd0, 32'd0, 32'd64);               // null payload
    issue(OP_SHRINK, 32'h0820, 32'd200, 32'd128);       // needs move
    issue(OP_SHRINK, 32'h0820, 32'd100, 32'd128);       // equal size
    issue(OP_SHRINK, 32'h0820, 32'd0, 32'd128);         // tail freed, merges
    issue(OP_SHRINK, 32'h0820, 32'hFFFF_FFF0, 32'd64);  // overflow on shrink
    issue(OP_SHRINK, 32'd0, 32'd40, 32'd0);             // null shrink allocates
    issue(OP_FREE, 32'h0810, 32'd0, 32'd0);             // empty block
    issue(OP_FREE, 32'h0810, 32'd0, 32'd47);
    issue(OP_ADD, 32'hFFFF_FF00, 32'h0000_0100, 32'd0); // region at top, wraps to zero
    issue(OP_ALLOC, 32'd0, 32'h0000_00E0, 32'd0);
    drain();
    // table full: many isolated regions, then a non-merging piece
    for (int i = 0; i < MAX_EXTENTS + 2; i++)
      issue(OP_ADD, 32'h8000_0000 + i * 32'h100, 32'h40, 32'd0);
    issue(OP_SHRINK, 32'h9000_0010, 32'd0, 32'h80);     // shrink with full table
    issue(OP_FREE, 32'hA000_0010, 32'd0, 32'h40);
    live_pay.delete();
    live_size.delete();

    // random: mostly well-formed alloc/free/shrink on live blocks, some noise
    for (int n = 0; n < 1250; n++) begin
      if (n == 600) drain();                            // sender waits for every result
      pick = $urandom_range(0, 99);
      if (pick < 6 || free_extents == 0) begin
        base = $urandom & 32'hFFFF_F000;
        issue(OP_ADD, base | $urandom_range(0, 15) * 16, $urandom_range(0, 32'h4000), $urandom);
      end else if (pick < 45) begin
        issue($urandom_range(0, 1) ? OP_ALLOC : OP_SHRINK, ($urandom_range(0, 1)) ? 32'd0 : 32'd0,
              ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 600), $urandom);
      end else if (pick < 70 && live_pay.size() > 0) begin
        touch_live(1'b1);
      end else if (pick < 92 && live_pay.size() > 0) begin
        touch_live(1'b0);
      end else begin
        issue(op_e'($urandom_range(1, 3)), $urandom, $urandom, $urandom);
      end
    end

    drain();
    if (fail_count == 0 && pending_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule
